// ===== rtl/lfust_pkg.sv =====
package lfust_pkg;

	localparam int IDX_W = 6;
	localparam int CNT_W = 7;
	localparam int KEY_W = 16;
	localparam int VOTE_W = 16;
	localparam int STAMP_W = 32;
	localparam int FRAMES_W = 6;

	typedef enum logic [1:0] {
		ST_HIT     = 2'd0,
		ST_INSERT  = 2'd1,
		ST_REPLACE = 2'd2,
		ST_LIST    = 2'd3
	} status_t;

	// values every cell sees while the chain sweeps
	typedef struct packed {
		logic                list_mode;
		logic [KEY_W-1:0]    key;
		logic                prev_v;
		logic [KEY_W-1:0]    prev_key;
		logic [STAMP_W-1:0]  now;
		logic [CNT_W-1:0]    count;
	} lfust_bcast_t;

	// slot write data, shared by all cells
	typedef struct packed {
		logic                full;
		logic [KEY_W-1:0]    key;
		logic [VOTE_W-1:0]   votes;
		logic [STAMP_W-1:0]  stamp;
	} lfust_wr_t;

	// word handed from cell to cell
	typedef struct packed {
		logic                hit;
		logic [IDX_W-1:0]    hit_idx;
		logic [VOTE_W-1:0]   hit_votes;
		logic                cand;
		logic [IDX_W-1:0]    cand_idx;
		logic [KEY_W-1:0]    cand_key;
		logic [VOTE_W-1:0]   cand_votes;
		logic [STAMP_W-1:0]  cand_age;
	} lfust_link_t;

endpackage

// ===== rtl/lfust_cell.sv =====
module lfust_cell import lfust_pkg::*; #(
	parameter int IDX = 0
) (
	input  logic         clk,
	input  lfust_bcast_t bc,
	input  lfust_wr_t    wr,
	input  logic         we,
	input  lfust_link_t  link_prev,
	output lfust_link_t  link_next
);

	logic [KEY_W-1:0]   key_q;
	logic [VOTE_W-1:0]  votes_q;
	logic [STAMP_W-1:0] stamp_q;
	lfust_link_t        link_q;

	logic               occ;
	logic               match;
	logic               take;
	logic [STAMP_W-1:0] age;
	lfust_link_t        link_d;

	always_ff @(posedge clk) begin
		if (we) begin
			votes_q <= wr.votes;
			if (wr.full) begin
				key_q   <= wr.key;
				stamp_q <= wr.stamp;
			end
		end
	end

	always_comb begin
		occ   = CNT_W'(IDX) < bc.count;
		age   = bc.now - stamp_q;
		match = occ && !bc.list_mode && (key_q == bc.key);
		if (bc.list_mode) begin
			// smallest key above the one listed last
			take = occ && (!bc.prev_v || key_q > bc.prev_key) &&
				(!link_prev.cand || key_q < link_prev.cand_key);
		end else begin
			// fewest votes, then oldest; earlier cell keeps full ties
			take = occ && (!link_prev.cand || votes_q < link_prev.cand_votes ||
				(votes_q == link_prev.cand_votes && age > link_prev.cand_age));
		end
		link_d = link_prev;
		if (match && !link_prev.hit) begin
			link_d.hit       = 1'b1;
			link_d.hit_idx   = IDX_W'(IDX);
			link_d.hit_votes = votes_q;
		end
		if (take) begin
			link_d.cand       = 1'b1;
			link_d.cand_idx   = IDX_W'(IDX);
			link_d.cand_key   = key_q;
			link_d.cand_votes = votes_q;
			link_d.cand_age   = age;
		end
	end

	always_ff @(posedge clk) begin
		link_q <= link_d;
	end

	assign link_next = link_q;

endmodule

// ===== rtl/lfu_slot_table_fifo_tiebreak_core.sv =====
// LFU slot table with oldest-first tie break.
// Input channel (in_valid / in_stall): operation 0 recommends student_key, 1 lists
// the occupied keys in ascending order. Output channel (out_valid / out_stall):
// one word per recommend, one word per occupied key for a list (last marks the
// final one), or a single word with entry_valid low when the table is empty.
// cfg_wr_en / cfg_wr_data write frames_in_use; the user writes it only while the
// block is idle, which the block itself does not enforce. Every decision is a
// sweep of a word through a chain of SLOTS cells, one cell per cycle; each cell
// holds one slot and compares it against the passing word.
// Recommend: the result is loaded into the output register after the sweep, and
// the next item is accepted only after the block has returned to idle.
// List of n keys: one sweep per key; an empty list takes one sweep.
// A finished word waits in the output register while the next item is accepted;
// if out_stall holds it, the block stops before loading the next word.
// Reset: table empty, stamp counter zero, frames_in_use 32; no clearing pass.
module lfu_slot_table_fifo_tiebreak_core import lfust_pkg::*; #(
	parameter int SLOTS = 32
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_wr_en,
	input  logic [FRAMES_W-1:0] cfg_wr_data,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic                operation,
	input  logic [KEY_W-1:0]    student_key,
	output logic                out_valid,
	input  logic                out_stall,
	output logic [1:0]          status,
	output logic [KEY_W-1:0]    entry_key,
	output logic [VOTE_W-1:0]   entry_votes,
	output logic                evicted_valid,
	output logic [KEY_W-1:0]    evicted_key,
	output logic                entry_valid,
	output logic                last
);

	localparam int CAP = (SLOTS < 32) ? SLOTS : 32;
	localparam int SW  = (SLOTS > 1) ? $clog2(SLOTS) : 1;

	typedef enum logic [2:0] {
		S_IDLE   = 3'b001,
		S_SWEEP  = 3'b010,
		S_DECIDE = 3'b100
	} state_t;

	state_t              state_q;
	logic [SW-1:0]       sweep_q;
	logic [CNT_W-1:0]    count_q;
	logic [CNT_W-1:0]    emit_q;
	logic [STAMP_W-1:0]  ctr_q;
	logic [FRAMES_W-1:0] frames_q;
	logic                list_q;
	logic [KEY_W-1:0]    req_key_q;
	logic                prev_v_q;
	logic [KEY_W-1:0]    prev_key_q;

	logic                out_valid_q;
	logic [1:0]          status_q;
	logic [KEY_W-1:0]    entry_key_q;
	logic [VOTE_W-1:0]   entry_votes_q;
	logic                evicted_valid_q;
	logic [KEY_W-1:0]    evicted_key_q;
	logic                entry_valid_q;
	logic                last_q;

	lfust_bcast_t        bc;
	lfust_wr_t           wr;
	lfust_link_t         link_w [SLOTS+1];
	lfust_link_t         link_out;
	logic [SLOTS-1:0]    cell_we;
	logic [IDX_W-1:0]    wr_idx;
	logic [CNT_W-1:0]    lim;
	logic                room;
	logic                fire;
	logic                in_take;
	logic [VOTE_W-1:0]   inc_votes;

	status_t             res_status;
	logic [KEY_W-1:0]    res_key;
	logic [VOTE_W-1:0]   res_votes;
	logic                res_ev;
	logic [KEY_W-1:0]    res_evk;
	logic                res_valid;
	logic                res_last;

	assign in_stall = (state_q != S_IDLE);
	assign in_take  = in_valid && !in_stall;
	assign fire     = (state_q == S_DECIDE) && (!out_valid_q || !out_stall);

	assign bc.list_mode = list_q;
	assign bc.key       = req_key_q;
	assign bc.prev_v    = prev_v_q;
	assign bc.prev_key  = prev_key_q;
	assign bc.now       = ctr_q;
	assign bc.count     = count_q;

	assign link_w[0] = '0;
	assign link_out  = link_w[SLOTS];

	genvar g;
	generate
		for (g = 0; g < SLOTS; g++) begin : g_cell
			assign cell_we[g] = fire && !list_q && (wr_idx == IDX_W'(g));
			lfust_cell #(.IDX(g)) u_cell (
				.clk       (clk),
				.bc        (bc),
				.wr        (wr),
				.we        (cell_we[g]),
				.link_prev (link_w[g]),
				.link_next (link_w[g+1])
			);
		end
	endgenerate

	always_comb begin
		if (frames_q == '0) begin
			lim = CNT_W'(1);
		end else if (CNT_W'(frames_q) > CNT_W'(CAP)) begin
			lim = CNT_W'(CAP);
		end else begin
			lim = CNT_W'(frames_q);
		end
	end

	assign room      = count_q < lim;
	assign inc_votes = (link_out.hit_votes == '1) ? link_out.hit_votes :
		link_out.hit_votes + VOTE_W'(1);

	always_comb begin
		wr_idx     = link_out.cand_idx;
		wr.full    = 1'b1;
		wr.key     = req_key_q;
		wr.votes   = VOTE_W'(1);
		wr.stamp   = ctr_q;
		res_status = ST_REPLACE;
		res_key    = req_key_q;
		res_votes  = VOTE_W'(1);
		res_ev     = 1'b0;
		res_evk    = '0;
		res_valid  = 1'b1;
		res_last   = 1'b1;
		if (list_q) begin
			res_status = ST_LIST;
			res_valid  = (count_q != '0);
			res_key    = res_valid ? link_out.cand_key : '0;
			res_votes  = res_valid ? link_out.cand_votes : '0;
			res_last   = !res_valid || ((emit_q + CNT_W'(1)) == count_q);
		end else if (link_out.hit) begin
			wr_idx     = link_out.hit_idx;
			wr.full    = 1'b0;
			wr.votes   = inc_votes;
			res_status = ST_HIT;
			res_votes  = inc_votes;
		end else if (room) begin
			wr_idx     = count_q[IDX_W-1:0];
			res_status = ST_INSERT;
		end else begin
			res_ev  = 1'b1;
			res_evk = link_out.cand_key;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			sweep_q     <= '0;
			count_q     <= '0;
			emit_q      <= '0;
			ctr_q       <= '0;
			frames_q    <= FRAMES_W'(32);
			prev_v_q    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				frames_q <= cfg_wr_data;
			end
			if (fire) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_take) begin
						state_q  <= S_SWEEP;
						sweep_q  <= '0;
						emit_q   <= '0;
						prev_v_q <= 1'b0;
					end
				end
				S_SWEEP: begin
					sweep_q <= sweep_q + SW'(1);
					if (sweep_q == SW'(SLOTS - 1)) begin
						state_q <= S_DECIDE;
					end
				end
				S_DECIDE: begin
					if (fire) begin
						if (list_q) begin
							emit_q   <= emit_q + CNT_W'(1);
							prev_v_q <= 1'b1;
							if (res_last) begin
								state_q <= S_IDLE;
							end else begin
								state_q <= S_SWEEP;
								sweep_q <= '0;
							end
						end else begin
							ctr_q   <= ctr_q + STAMP_W'(1);
							state_q <= S_IDLE;
							if (!link_out.hit && room) begin
								count_q <= count_q + CNT_W'(1);
							end
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			list_q    <= operation;
			req_key_q <= student_key;
		end
		if (fire && list_q) begin
			prev_key_q <= link_out.cand_key;
		end
		if (fire) begin
			status_q        <= res_status;
			entry_key_q     <= res_key;
			entry_votes_q   <= res_votes;
			evicted_valid_q <= res_ev;
			evicted_key_q   <= res_evk;
			entry_valid_q   <= res_valid;
			last_q          <= res_last;
		end
	end

	assign out_valid     = out_valid_q;
	assign status        = status_q;
	assign entry_key     = entry_key_q;
	assign entry_votes   = entry_votes_q;
	assign evicted_valid = evicted_valid_q;
	assign evicted_key   = evicted_key_q;
	assign entry_valid   = entry_valid_q;
	assign last          = last_q;

`ifndef ASSERT_OFF
	a_count_steps: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q != $past(count_q)) |-> (count_q == $past(count_q) + CNT_W'(1)))
		else $error("occupancy moved by more than one");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(SLOTS))
		else $error("occupancy beyond slot count");

	a_write_decide: assert property (@(posedge clk) disable iff (!arst_n)
		(cell_we != '0) |-> (state_q == S_DECIDE && !list_q && $onehot(cell_we)))
		else $error("slot write outside a recommend decision");

	a_victim_found: assert property (@(posedge clk) disable iff (!arst_n)
		(fire && !list_q && !link_out.hit && !room) |-> link_out.cand)
		else $error("replacement without a victim");

	a_list_order: assert property (@(posedge clk) disable iff (!arst_n)
		(fire && list_q && prev_v_q) |-> (link_out.cand_key > prev_key_q))
		else $error("list keys out of order");
`endif

endmodule
